// ----- rtl/otsb_pkg.sv -----
// otsb_pkg: types, codes and constants shared by the one-shot timer bank
// no dependencies; imported by otsb_alu, otsb_ctrl and one_shot_timer_bank_unit

package otsb_pkg;

    // bank size default and field widths
    localparam int SLOT_COUNT_DEFAULT = 16;
    localparam int WORD_W             = 32;
    localparam int SLOT_FIELD_W       = 4;

    // command codes
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_DEL  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_DEL  = 2'd1;
    localparam logic [1:0] KIND_FIRE = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_DEL_FREE = 2'd2;

    // slot status codes
    localparam logic [1:0] SLOT_FREE    = 2'd0;
    localparam logic [1:0] SLOT_ARMED   = 2'd1;
    localparam logic [1:0] SLOT_FIRED   = 2'd2;
    localparam logic [1:0] SLOT_PENDING = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_WRITE,
        ST_DEL,
        ST_TICK_INC,
        ST_SCAN,
        ST_DONE
    } state_t;

    // input request
    typedef struct packed {
        logic [1:0]              command;
        logic [WORD_W-1:0]       delay_seconds;
        logic [WORD_W-1:0]       user_word;
        logic [SLOT_FIELD_W-1:0] slot_index;
    } cmd_req_t;

    // result item
    typedef struct packed {
        logic [1:0]              kind;
        logic [1:0]              status;
        logic [SLOT_FIELD_W-1:0] slot_out;
        logic [WORD_W-1:0]       user_word_out;
        logic                    last;
    } evt_rsp_t;

    // shared adder operands and result
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              carry_in;
    } alu_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] sum;
        logic              carry_out;
    } alu_rsp_t;

endpackage

// ----- rtl/otsb_ram.sv -----
// otsb_ram: generic single-write, single-read RAM with registered read data
// depends on nothing but its parameters

module otsb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/otsb_alu.sv -----
// otsb_alu: shared 32-bit adder with carry in and carry out
// depends on otsb_pkg for the operand and result structs

module otsb_alu
    import otsb_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    // one adder serves saturating add, increment and compare
    assign {rsp.carry_out, rsp.sum} = {1'b0, req.a} + {1'b0, req.b}
                                      + {{WORD_W{1'b0}}, req.carry_in};

endmodule

// ----- rtl/otsb_ctrl.sv -----
// otsb_ctrl: sequencer, slot status flops, second counter and output register
// depends on otsb_pkg; drives the shared adder and the deadline/word RAM

module otsb_ctrl
    import otsb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
    localparam int SLOT_W = $clog2(SLOT_COUNT),
    localparam int SLOT_DEPTH = 1 << SLOT_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_req_t              cmd,
    output logic                  evt_valid,
    input  logic                  evt_stall,
    output evt_rsp_t              evt,
    output alu_req_t              alu_req,
    input  alu_rsp_t              alu_rsp,
    output logic                  ram_wr_en,
    output logic [SLOT_W-1:0]     ram_wr_addr,
    output logic [2*WORD_W-1:0]   ram_wr_data,
    output logic                  ram_rd_en,
    output logic [SLOT_W-1:0]     ram_rd_addr,
    input  logic [2*WORD_W-1:0]   ram_rd_data
);

    state_t                  state_reg, state_next;
    cmd_req_t                req_reg;
    logic [SLOT_W-1:0]       addr_reg, addr_next;
    logic [WORD_W-1:0]       seconds_reg, seconds_next;
    logic                    out_valid_reg;
    evt_rsp_t                out_reg;
    logic [1:0]              status_reg [SLOT_DEPTH];

    logic                    accept;
    logic                    out_free;
    logic                    out_load;
    evt_rsp_t                out_data;
    logic                    status_we;
    logic [1:0]              status_wdata;
    logic [1:0]              cur_status;
    logic                    last_slot;
    logic                    fire;
    logic                    scan_go;
    logic                    del_oob;
    logic [SLOT_W+3:0]       idx_ext;
    logic [SLOT_W+3:0]       addr_ext;
    logic [SLOT_W-1:0]       cmd_addr;
    logic [SLOT_FIELD_W-1:0] addr_slot;

    function automatic logic [SLOT_W-1:0] idx_ext_of(input logic [SLOT_FIELD_W-1:0] idx);
        logic [SLOT_W+3:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

    // handshake and common decodes
    assign accept     = cmd_valid && !cmd_stall;
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign out_free   = !out_valid_reg || !evt_stall;
    assign evt_valid  = out_valid_reg;
    assign evt        = out_reg;
    assign cur_status = status_reg[addr_reg];
    assign last_slot  = (addr_reg == SLOT_W'(SLOT_COUNT - 1));
    assign fire       = (cur_status == SLOT_ARMED) && alu_rsp.carry_out;
    assign scan_go    = !fire || out_free;

    // slot handle conversions between the 4-bit field and the internal index
    assign idx_ext   = {{SLOT_W{1'b0}}, req_reg.slot_index};
    assign del_oob   = (idx_ext >= (SLOT_W + 4)'(SLOT_COUNT));
    assign cmd_addr  = idx_ext_of(cmd.slot_index);
    assign addr_ext  = {4'b0000, addr_reg};
    assign addr_slot = addr_ext[SLOT_FIELD_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.command)
                        CMD_ADD:  state_next = ST_ADD_SCAN;
                        CMD_DEL:  state_next = ST_DEL;
                        CMD_TICK: state_next = ST_TICK_INC;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_SCAN:
            begin
                priority if (cur_status == SLOT_FREE)
                begin
                    state_next = ST_ADD_WRITE;
                end
                else if (last_slot && out_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ADD_SCAN;
                end
            end
            ST_ADD_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_INC:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_go && last_slot)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control and result formation
    always_comb
    begin
        addr_next     = addr_reg;
        seconds_next  = seconds_reg;
        status_we     = 1'b0;
        status_wdata  = SLOT_FREE;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = addr_reg;
        ram_wr_data   = {alu_rsp.carry_out ? {WORD_W{1'b1}} : alu_rsp.sum,
                         req_reg.user_word};
        ram_rd_en     = 1'b0;
        ram_rd_addr   = addr_reg + SLOT_W'(1);
        alu_req.a        = seconds_reg;
        alu_req.b        = ~ram_rd_data[2*WORD_W-1:WORD_W];
        alu_req.carry_in = 1'b1;
        out_load      = 1'b0;
        out_data      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = (cmd.command == CMD_DEL) ? cmd_addr : '0;
                end
            end
            ST_ADD_SCAN:
            begin
                priority if (cur_status == SLOT_FREE)
                begin
                    addr_next = addr_reg;
                end
                else if (last_slot)
                begin
                    if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_data.kind   = KIND_ADD;
                        out_data.status = STATUS_FULL;
                        out_data.last   = 1'b1;
                    end
                end
                else
                begin
                    addr_next = addr_reg + SLOT_W'(1);
                end
            end
            ST_ADD_WRITE:
            begin
                // deadline is now plus delay, saturated on carry out
                alu_req.b        = req_reg.delay_seconds;
                alu_req.carry_in = 1'b0;
                if (out_free)
                begin
                    ram_wr_en         = 1'b1;
                    status_we         = 1'b1;
                    status_wdata      = SLOT_ARMED;
                    out_load          = 1'b1;
                    out_data.kind     = KIND_ADD;
                    out_data.status   = STATUS_OK;
                    out_data.slot_out = addr_slot;
                    out_data.last     = 1'b1;
                end
            end
            ST_DEL:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_data.kind     = KIND_DEL;
                    out_data.slot_out = req_reg.slot_index;
                    out_data.last     = 1'b1;
                    if (del_oob || cur_status == SLOT_FREE)
                    begin
                        out_data.status = STATUS_DEL_FREE;
                    end
                    else
                    begin
                        out_data.status = STATUS_OK;
                        status_we       = 1'b1;
                        status_wdata    = SLOT_PENDING;
                    end
                end
            end
            ST_TICK_INC:
            begin
                // saturating increment, prefetch of the first slot
                alu_req.b        = '0;
                alu_req.carry_in = 1'b1;
                seconds_next     = alu_rsp.carry_out ? seconds_reg : alu_rsp.sum;
                ram_rd_en        = 1'b1;
                ram_rd_addr      = '0;
                addr_next        = '0;
            end
            ST_SCAN:
            begin
                // compare now against deadline, one slot per cycle unless a firing slot waits on a stalled output
                if (scan_go)
                begin
                    if (cur_status == SLOT_PENDING)
                    begin
                        status_we    = 1'b1;
                        status_wdata = SLOT_FREE;
                    end
                    else if (fire)
                    begin
                        status_we              = 1'b1;
                        status_wdata           = SLOT_FIRED;
                        out_load               = 1'b1;
                        out_data.kind          = KIND_FIRE;
                        out_data.status        = STATUS_OK;
                        out_data.slot_out      = addr_slot;
                        out_data.user_word_out = ram_rd_data[WORD_W-1:0];
                    end
                    if (!last_slot)
                    begin
                        addr_next = addr_reg + SLOT_W'(1);
                        ram_rd_en = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_data.kind = KIND_DONE;
                    out_data.last = 1'b1;
                end
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seconds_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seconds_reg <= seconds_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!evt_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (accept)
        begin
            req_reg <= cmd;
        end
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    // slot status flops, all free after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_DEPTH; i++)
            begin
                status_reg[i] <= SLOT_FREE;
            end
        end
        else if (status_we)
        begin
            status_reg[addr_reg] <= status_wdata;
        end
    end

endmodule

// ----- rtl/one_shot_timer_bank_unit.sv -----
// one_shot_timer_bank_unit: one request at a time, handled by the slot walk of the sequencer.
// add: first-free search, one slot a cycle; delete: the named slot only.
// tick: one slot a cycle through the deadline RAM read port and the shared adder,
// held while a firing slot waits on a stalled output. No new request while busy.
// reset: asynchronous, all slots free and the second count zero; deadline RAM not cleared.
// depends on otsb_pkg, otsb_ctrl, otsb_alu and otsb_ram

module one_shot_timer_bank_unit
    import otsb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
    localparam int SLOT_W = $clog2(SLOT_COUNT)
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  cmd_req_t cmd,
    output logic     evt_valid,
    input  logic     evt_stall,
    output evt_rsp_t evt
);

    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;
    logic                  ram_wr_en;
    logic [SLOT_W-1:0]     ram_wr_addr;
    logic [2*WORD_W-1:0]   ram_wr_data;
    logic                  ram_rd_en;
    logic [SLOT_W-1:0]     ram_rd_addr;
    logic [2*WORD_W-1:0]   ram_rd_data;

    // sequencer
    otsb_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .evt         (evt),
        .alu_req     (alu_req),
        .alu_rsp     (alu_rsp),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // shared adder
    otsb_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // deadline and user word store
    otsb_ram #(
        .WIDTH (2 * WORD_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule
